// File: src/bit_file_header_parser_assert.svh
// assertion macros for the configuration file header parser
// no dependencies; included by the modules that check their own logic
`ifndef BIT_FILE_HEADER_PARSER_ASSERT_SVH
`define BIT_FILE_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked in the same cycle, quiet during reset
`define BFHP_ASSERT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// implication checked in the next cycle, quiet during reset
`define BFHP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BFHP_ASSERT(label, clk, rst_n, pre, post, msg)
`define BFHP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// File: src/bfhp_pkg.sv
// types and constants of the configuration file header parser
// no dependencies; used by the top level and the testbench
`default_nettype none

package bfhp_pkg;

    // key byte of the first header field and index of the last key
    localparam logic [7:0] KEY_FIRST      = 8'h61;
    localparam logic [2:0] KEY_LAST_INDEX = 3'd4;

    // codes of the field kind on the result word
    localparam logic [2:0] KIND_SKIP   = 3'd0;
    localparam logic [2:0] KIND_STREAM = 3'd5;
    localparam logic [2:0] KIND_AFTER  = 3'd6;

    // parser phase, one-hot
    typedef enum logic [5:0] {
        PH_SEARCH  = 6'b000001,
        PH_LEN16   = 6'b000010,
        PH_PAYLOAD = 6'b000100,
        PH_LEN32   = 6'b001000,
        PH_STREAM  = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    // one result word
    typedef struct packed {
        logic [2:0]  field_kind;
        logic [7:0]  data_byte;
        logic        field_last;
        logic [31:0] stream_length;
        logic        length_valid;
        logic        done_res;
    } t_res;

endpackage

`default_nettype wire

// File: src/bfhp_if.sv
// valid/ready channels of the configuration file header parser
// input byte channel and result channel; depend on nothing but each other's style
`default_nettype none

// input channel: one file byte per word
interface bfhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// result channel: one tagged byte with length and done status per word
interface bfhp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  field_kind;
    logic [7:0]  data_byte;
    logic        field_last;
    logic [31:0] stream_length;
    logic        length_valid;
    logic        done_res;

    modport source (
        output valid, output field_kind, output data_byte, output field_last,
        output stream_length, output length_valid, output done_res,
        input ready
    );
    modport sink (
        input valid, input field_kind, input data_byte, input field_last,
        input stream_length, input length_valid, input done_res,
        output ready
    );
endinterface

`default_nettype wire

// File: src/bit_file_header_parser.sv
// Configuration file header parser. Takes one file byte per word and returns one
// result word per byte. The header fields behind keys 'a' to 'd' are tagged as
// design name, part name, date and time with the last byte of each marked; bytes
// before a key, keys and length bytes come out as kind 0. After key 'e' four
// big-endian length bytes give the bitstream length, that many bytes pass through
// as kind 5, and every later byte comes out as kind 6 with done set. A byte is
// taken in every cycle it is not held off: the parser state updates in the
// cycle a byte is accepted and the result lands in an output register. While the
// output register is full and not taken, the input is held off.
// Depends on bfhp_pkg, bfhp_if.sv and bit_file_header_parser_assert.svh.
`default_nettype none
`include "bit_file_header_parser_assert.svh"

module bit_file_header_parser
    import bfhp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bfhp_in_if.sink    i_in,
    bfhp_out_if.source o_res
);

    // parser state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_field_index, n_field_index;
    logic [1:0]  r_len_seen, n_len_seen;
    logic [31:0] r_len_shift, n_len_shift;
    logic [31:0] r_bytes_left, n_bytes_left;

    // output register
    t_res        r_res, n_res;
    logic        r_res_valid;

    logic        in_fire;
    logic        len_done;
    logic [7:0]  key_byte;

    // accept while the output register is empty or being emptied
    assign i_in.ready = !r_res_valid || o_res.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign key_byte   = KEY_FIRST + {5'b0, r_field_index};

    // next state and result word for the byte at the input
    always_comb begin
        n_phase       = r_phase;
        n_field_index = r_field_index;
        n_len_seen    = r_len_seen;
        n_len_shift   = r_len_shift;
        n_bytes_left  = r_bytes_left;
        n_res         = '0;
        n_res.field_kind = KIND_SKIP;
        unique case (r_phase)
            PH_SEARCH: begin
                if (r_field_index <= KEY_LAST_INDEX && i_in.in_byte == key_byte) begin
                    n_len_seen = 2'd0;
                    if (r_field_index == KEY_LAST_INDEX) begin
                        n_len_shift = '0;
                        n_phase     = PH_LEN32;
                    end else begin
                        n_bytes_left = '0;
                        n_phase      = PH_LEN16;
                    end
                end
            end
            PH_LEN16: begin
                n_bytes_left = {16'b0, r_bytes_left[7:0], i_in.in_byte};
                if (r_len_seen == 2'd0) begin
                    n_len_seen = 2'd1;
                end else begin
                    n_len_seen = 2'd0;
                    if (n_bytes_left[15:0] == 16'd0) begin
                        n_field_index = r_field_index + 3'd1;
                        n_phase       = PH_SEARCH;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_res.field_kind = r_field_index + 3'd1;
                n_res.data_byte  = i_in.in_byte;
                if (r_bytes_left[31:1] == 31'd0) begin
                    n_res.field_last = 1'b1;
                    n_bytes_left     = '0;
                    n_field_index    = r_field_index + 3'd1;
                    n_phase          = PH_SEARCH;
                end else begin
                    n_bytes_left = r_bytes_left - 32'd1;
                end
            end
            PH_LEN32: begin
                n_len_shift = {r_len_shift[23:0], i_in.in_byte};
                if (r_len_seen == 2'd3) begin
                    n_len_seen   = 2'd0;
                    n_bytes_left = n_len_shift;
                    n_phase      = (n_len_shift == 32'd0) ? PH_DONE : PH_STREAM;
                end else begin
                    n_len_seen = r_len_seen + 2'd1;
                end
            end
            PH_STREAM: begin
                n_res.field_kind = KIND_STREAM;
                n_res.data_byte  = i_in.in_byte;
                if (r_bytes_left[31:1] == 31'd0) begin
                    n_res.field_last = 1'b1;
                    n_bytes_left     = '0;
                    n_phase          = PH_DONE;
                end else begin
                    n_bytes_left = r_bytes_left - 32'd1;
                end
            end
            PH_DONE: begin
                n_res.field_kind = KIND_AFTER;
            end
            default: begin
                n_res.field_kind = KIND_AFTER;
            end
        endcase
        // status flags follow the state after this byte
        len_done           = (n_phase == PH_STREAM) || (n_phase == PH_DONE);
        n_res.length_valid = len_done;
        n_res.done_res     = (n_phase == PH_DONE);
        n_res.stream_length = len_done ? n_len_shift : 32'd0;
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SEARCH;
            r_field_index <= 3'd0;
            r_len_seen    <= 2'd0;
            r_len_shift   <= '0;
            r_bytes_left  <= '0;
        end else if (in_fire) begin
            r_phase       <= n_phase;
            r_field_index <= n_field_index;
            r_len_seen    <= n_len_seen;
            r_len_shift   <= n_len_shift;
            r_bytes_left  <= n_bytes_left;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (in_fire) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    // result channel
    assign o_res.valid         = r_res_valid;
    assign o_res.field_kind    = r_res.field_kind;
    assign o_res.data_byte     = r_res.data_byte;
    assign o_res.field_last    = r_res.field_last;
    assign o_res.stream_length = r_res.stream_length;
    assign o_res.length_valid  = r_res.length_valid;
    assign o_res.done_res      = r_res.done_res;

    // checks on the parser's own logic
    `BFHP_ASSERT(a_key_index_range, i_clk, i_rst_n, 1'b1, r_field_index <= KEY_LAST_INDEX, "key index beyond last key")
    `BFHP_ASSERT(a_len32_last_key, i_clk, i_rst_n, r_phase == PH_LEN32, r_field_index == KEY_LAST_INDEX, "stream length read before last key")
    `BFHP_ASSERT(a_count_nonzero, i_clk, i_rst_n, r_phase == PH_PAYLOAD || r_phase == PH_STREAM, r_bytes_left != 32'd0, "payload phase with no bytes left")
    `BFHP_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, r_phase == PH_DONE, r_phase == PH_DONE, "parser left the end phase")
    `BFHP_ASSERT(a_last_on_payload, i_clk, i_rst_n, r_res_valid && r_res.field_last, r_res.field_kind != KIND_SKIP && r_res.field_kind != KIND_AFTER, "last flag on a non-payload byte")

endmodule

`default_nettype wire

// File: tb/bit_file_header_parser_tb.sv
// testbench of the configuration file header parser: one file fed byte by byte
// depends on bfhp_pkg, bfhp_if.sv and bit_file_header_parser
`default_nettype none

module bit_file_header_parser_tb
    import bfhp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_BYTES = 1250;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_HOLD    = 40;
    localparam int HOLD_AT      = 60;
    localparam int STALL_LIMIT  = 1000;

    logic i_clk;
    logic i_rst_n;

    bfhp_in_if  in_ch ();
    bfhp_out_if res_ch ();

    bit_file_header_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    // file bytes waiting to be sent and tagged bytes waiting to come back
    logic [7:0] file_bytes[$];
    t_res       tagged_due[$];

    int total_bytes;
    int key_e_pos;
    int bytes_offered;
    int bytes_taken;
    int words_seen;
    int errors;
    int send_gap;
    int recv_hold;
    bit long_hold_done;
    int idle_cycles;
    int kind_seen[8];
    logic [31:0] file_stream_len;
    t_res got_w;
    t_res due_w;

    // parser state as predicted
    t_phase      pr_phase;
    logic [2:0]  pr_key_idx;
    logic [1:0]  pr_len_cnt;
    logic [31:0] pr_stream_len;
    logic [31:0] pr_remaining;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // tag one file byte and advance the predicted parser state
    function automatic t_res tag_byte(input logic [7:0] b);
        t_res r;
        logic is_valid;
        r = '0;
        r.field_kind = KIND_SKIP;
        case (pr_phase)
            PH_SEARCH: begin
                if (pr_key_idx <= KEY_LAST_INDEX && b == KEY_FIRST + {5'b0, pr_key_idx}) begin
                    pr_len_cnt = 2'd0;
                    if (pr_key_idx == KEY_LAST_INDEX) begin
                        pr_stream_len = '0;
                        pr_phase = PH_LEN32;
                    end else begin
                        pr_remaining = '0;
                        pr_phase = PH_LEN16;
                    end
                end
            end
            PH_LEN16: begin
                pr_remaining = {16'h0, pr_remaining[7:0], b};
                if (pr_len_cnt == 2'd0) begin
                    pr_len_cnt = 2'd1;
                end else begin
                    pr_len_cnt = 2'd0;
                    if (pr_remaining == 0) begin
                        pr_key_idx = pr_key_idx + 3'd1;
                        pr_phase = PH_SEARCH;
                    end else begin
                        pr_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                r.field_kind = pr_key_idx + 3'd1;
                r.data_byte = b;
                if (pr_remaining <= 1) begin
                    r.field_last = 1'b1;
                    pr_remaining = '0;
                    pr_key_idx = pr_key_idx + 3'd1;
                    pr_phase = PH_SEARCH;
                end else begin
                    pr_remaining = pr_remaining - 1;
                end
            end
            PH_LEN32: begin
                pr_stream_len = {pr_stream_len[23:0], b};
                if (pr_len_cnt == 2'd3) begin
                    pr_len_cnt = 2'd0;
                    pr_remaining = pr_stream_len;
                    pr_phase = (pr_remaining == 0) ? PH_DONE : PH_STREAM;
                end else begin
                    pr_len_cnt = pr_len_cnt + 2'd1;
                end
            end
            PH_STREAM: begin
                r.field_kind = KIND_STREAM;
                r.data_byte = b;
                if (pr_remaining <= 1) begin
                    r.field_last = 1'b1;
                    pr_remaining = '0;
                    pr_phase = PH_DONE;
                end else begin
                    pr_remaining = pr_remaining - 1;
                end
            end
            default: begin
                r.field_kind = KIND_AFTER;
            end
        endcase
        is_valid = (pr_phase == PH_STREAM) || (pr_phase == PH_DONE);
        r.stream_length = is_valid ? pr_stream_len : '0;
        r.length_valid = is_valid;
        r.done_res = (pr_phase == PH_DONE);
        return r;
    endfunction

    // junk byte that never matches the awaited key, often another key letter
    function automatic logic [7:0] junk_byte(input logic [2:0] key_idx);
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 3) == 0)
                b = KEY_FIRST + 8'($urandom_range(0, 4));
            else
                b = 8'($urandom_range(0, 255));
        end while (b == KEY_FIRST + {5'b0, key_idx});
        return b;
    endfunction

    // random content byte, key letters mixed in
    function automatic logic [7:0] content_byte();
        if ($urandom_range(0, 4) == 0)
            return KEY_FIRST + 8'($urandom_range(0, 4));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_junk(input logic [2:0] key_idx, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(junk_byte(key_idx));
    endtask

    task automatic add_field(input logic [2:0] key_idx, input int len);
        logic [15:0] l16;
        l16 = 16'(len);
        file_bytes.push_back(KEY_FIRST + {5'b0, key_idx});
        file_bytes.push_back(l16[15:8]);
        file_bytes.push_back(l16[7:0]);
        for (int i = 0; i < len; i++)
            file_bytes.push_back(content_byte());
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("word %0d: %s is %0h, expected %0h", words_seen, what, got, want);
        errors++;
    endtask

    // byte driver: offers queued file bytes, predicts each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.in_byte <= 8'h00;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                tagged_due.push_back(tag_byte(in_ch.in_byte));
                bytes_taken++;
                if (bytes_taken < total_bytes - QUIET_TAIL && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 3);
            end
            if (in_ch.valid && !in_ch.ready) begin
                // word still on offer, hold it
            end else if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (file_bytes.size() == 0 ||
                         (bytes_offered == key_e_pos && tagged_due.size() != 0)) begin
                // out of bytes, or draining the block before the last key
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid   <= 1'b1;
                in_ch.in_byte <= file_bytes.pop_front();
                bytes_offered++;
            end
        end
    end

    // result monitor and ready with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got_w = '{res_ch.field_kind, res_ch.data_byte, res_ch.field_last,
                          res_ch.stream_length, res_ch.length_valid, res_ch.done_res};
                if (tagged_due.size() == 0) begin
                    report_mismatch("unexpected word, kind", 32'(got_w.field_kind), 32'h0);
                end else begin
                    due_w = tagged_due.pop_front();
                    if (got_w.field_kind !== due_w.field_kind)
                        report_mismatch("field_kind", 32'(got_w.field_kind),
                                        32'(due_w.field_kind));
                    if (got_w.data_byte !== due_w.data_byte)
                        report_mismatch("data_byte", 32'(got_w.data_byte),
                                        32'(due_w.data_byte));
                    if (got_w.field_last !== due_w.field_last)
                        report_mismatch("field_last", 32'(got_w.field_last),
                                        32'(due_w.field_last));
                    if (got_w.stream_length !== due_w.stream_length)
                        report_mismatch("stream_length", got_w.stream_length,
                                        due_w.stream_length);
                    if (got_w.length_valid !== due_w.length_valid)
                        report_mismatch("length_valid", 32'(got_w.length_valid),
                                        32'(due_w.length_valid));
                    if (got_w.done_res !== due_w.done_res)
                        report_mismatch("done_res", 32'(got_w.done_res),
                                        32'(due_w.done_res));
                end
                kind_seen[got_w.field_kind]++;
                words_seen++;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                res_ch.ready <= 1'b0;
            end else if (!long_hold_done && words_seen >= HOLD_AT) begin
                long_hold_done = 1'b1;
                recv_hold = LONG_HOLD - 1;
                res_ch.ready <= 1'b0;
            end else if (words_seen < total_bytes - QUIET_TAIL &&
                         $urandom_range(0, 4) == 0) begin
                recv_hold = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        res_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        pr_phase      = PH_SEARCH;
        pr_key_idx    = 3'd0;
        pr_len_cnt    = 2'd0;
        pr_stream_len = '0;
        pr_remaining  = '0;

        // directed header start: junk with extremes and wrong keys before 'a'
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(KEY_FIRST + 8'd4);
        file_bytes.push_back(KEY_FIRST + 8'd1);
        file_bytes.push_back(KEY_FIRST - 8'd1);
        // design name of four bytes holding key letters and extremes
        file_bytes.push_back(KEY_FIRST);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h04);
        file_bytes.push_back(KEY_FIRST);
        file_bytes.push_back(KEY_FIRST + 8'd4);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        // empty part name
        add_field(3'd1, 0);

        // random rest of the header; the time field has a nonzero high length byte
        add_junk(3'd2, $urandom_range(0, 6));
        add_field(3'd2, $urandom_range(1, 80));
        add_junk(3'd3, $urandom_range(0, 6));
        add_field(3'd3, $urandom_range(256, 300));
        add_junk(3'd4, $urandom_range(0, 6));

        // bitstream length, now and then zero, then the raw bytes
        key_e_pos = file_bytes.size();
        file_bytes.push_back(KEY_FIRST + 8'd4);
        file_stream_len = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(500, 750));
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(file_stream_len[8*i +: 8]);
        for (int i = 0; i < file_stream_len; i++)
            file_bytes.push_back(content_byte());

        // bytes past the end of the bitstream
        if (file_bytes.size() + 60 > TARGET_BYTES)
            add_junk(3'd7, 60);
        else
            add_junk(3'd7, TARGET_BYTES - file_bytes.size());
        total_bytes = file_bytes.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < total_bytes || tagged_due.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("file of %0d bytes, bitstream length %0d: %0d skipped/key/length words,",
                 total_bytes, file_stream_len, kind_seen[0]);
        $display("%0d header payload, %0d bitstream and %0d past-end words; %0d errors",
                 kind_seen[1] + kind_seen[2] + kind_seen[3] + kind_seen[4],
                 kind_seen[5], kind_seen[6], errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
